FILE: sv/qrm_pkg.sv
`default_nettype none
package qrm_pkg;
    localparam int DEFAULT_FRAC_BITS = 14;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int PROD_W = 2 * IN_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int NORM_W = PROD_W + 1;
    localparam int N_PROD = 10;
    localparam int N_ENT  = 9;
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN_MAG = 32768;

    // product slots
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_WX = 4;
    localparam int P_WY = 5;
    localparam int P_WZ = 6;
    localparam int P_XY = 7;
    localparam int P_XZ = 8;
    localparam int P_YZ = 9;
endpackage
`default_nettype wire

FILE: sv/quaternion_to_rotation_matrix_core.sv
// Quaternion to 3x3 rotation matrix. Takes one quaternion (w, x, y, z, signed fixed point
// with FRAC_BITS fraction bits) per cycle and returns the nine matrix entries of the
// normalized rotation, rounded to nearest with ties away from zero and saturated to 16 bits.
// An all-zero quaternion gives the identity and raises the zero_norm flag in m_tuser.
// The stages are one of products, one of sums, FRAC_BITS + 2
// stages of a restoring divider (nine compare-subtract lanes, one quotient bit each),
// and an output stage for rounding and saturation. Throughput is one transfer per cycle;
// the whole pipeline holds while the output is stalled.
`default_nettype none
module quaternion_to_rotation_matrix_core #(
    parameter int FRAC_BITS = qrm_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    input  wire logic [63:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each from bit 0 up
    output logic [143:0]      m_tdata,
    // zero_norm [0]
    output logic              m_tuser
);
    import qrm_pkg::*;

    localparam int DIV_ST = FRAC_BITS + 2;
    localparam int T_W    = FRAC_BITS + 2;
    localparam int CMP_W  = T_W + 17;
    localparam int ONE_VAL = (FRAC_BITS >= 15) ? OUT_MAX : (1 << FRAC_BITS);
    // most negative diagonal value, minus one clamps to the 16-bit floor
    localparam int DIAG_MIN_MAG = (FRAC_BITS >= 15) ? OUT_MIN_MAG : (1 << FRAC_BITS);

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 1: products
    logic                     p1_vld_reg;
    logic signed [PROD_W-1:0] prod_reg [N_PROD];
    logic signed [IN_W-1:0]   qw, qx, qy, qz;
    assign qw = $signed(s_tdata[15:0]);
    assign qx = $signed(s_tdata[31:16]);
    assign qy = $signed(s_tdata[47:32]);
    assign qz = $signed(s_tdata[63:48]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else if (adv)
            p1_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[P_WW] <= qw * qw;
            prod_reg[P_XX] <= qx * qx;
            prod_reg[P_YY] <= qy * qy;
            prod_reg[P_ZZ] <= qz * qz;
            prod_reg[P_WX] <= qw * qx;
            prod_reg[P_WY] <= qw * qy;
            prod_reg[P_WZ] <= qw * qz;
            prod_reg[P_XY] <= qx * qy;
            prod_reg[P_XZ] <= qx * qz;
            prod_reg[P_YZ] <= qy * qz;
        end
    end

    // stage 2: norm, numerators as sign and magnitude
    logic signed [SUM_W-1:0] e [N_PROD];
    logic signed [SUM_W-1:0] nsum;
    logic signed [SUM_W-1:0] num [N_ENT];
    logic [NORM_W-1:0]       mag_next [N_ENT];
    logic [N_ENT-1:0]        neg_next;

    always_comb
    begin
        for (int i = 0; i < N_PROD; i++)
            e[i] = SUM_W'(prod_reg[i]);
        nsum   = e[P_WW] + e[P_XX] + e[P_YY] + e[P_ZZ];
        num[0] = nsum - 2 * (e[P_YY] + e[P_ZZ]);
        num[1] = 2 * (e[P_XY] - e[P_WZ]);
        num[2] = 2 * (e[P_XZ] + e[P_WY]);
        num[3] = 2 * (e[P_XY] + e[P_WZ]);
        num[4] = nsum - 2 * (e[P_XX] + e[P_ZZ]);
        num[5] = 2 * (e[P_YZ] - e[P_WX]);
        num[6] = 2 * (e[P_XZ] - e[P_WY]);
        num[7] = 2 * (e[P_YZ] + e[P_WX]);
        num[8] = nsum - 2 * (e[P_XX] + e[P_YY]);
        for (int i = 0; i < N_ENT; i++)
        begin
            neg_next[i] = num[i][SUM_W-1];
            mag_next[i] = neg_next[i] ? NORM_W'(-num[i]) : NORM_W'(num[i]);
        end
    end

    logic                 p2_vld_reg;
    logic [NORM_W-1:0]    p2_den_reg;
    logic [NORM_W-1:0]    p2_mag_reg [N_ENT];
    logic [N_ENT-1:0]     p2_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_vld_reg <= 1'b0;
        else if (adv)
            p2_vld_reg <= p1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_den_reg <= NORM_W'(nsum);
            p2_mag_reg <= mag_next;
            p2_neg_reg <= neg_next;
        end
    end

    // divider stages: one quotient bit of floor(mag * 2^(FRAC_BITS+1) / den) each
    logic                 d_vld_reg [DIV_ST];
    logic [NORM_W-1:0]    d_den_reg [DIV_ST];
    logic [N_ENT-1:0]     d_neg_reg [DIV_ST];
    logic [NORM_W-1:0]    d_rem_reg [DIV_ST][N_ENT];
    logic [T_W-1:0]       d_t_reg   [DIV_ST][N_ENT];

    for (genvar g = 0; g < DIV_ST; g++)
    begin : g_div
        logic              vld_in;
        logic [NORM_W-1:0] den_in;
        logic [N_ENT-1:0]  neg_in;
        logic [NORM_W:0]   rem2 [N_ENT];
        logic [T_W-1:0]    t_in [N_ENT];
        logic [NORM_W:0]   den_x;
        logic              qbit [N_ENT];
        logic [NORM_W:0]   diff [N_ENT];
        logic [NORM_W-1:0] rem_next [N_ENT];
        logic [T_W-1:0]    t_next [N_ENT];

        if (g == 0)
        begin : g_first
            always_comb
            begin
                vld_in = p2_vld_reg;
                den_in = p2_den_reg;
                neg_in = p2_neg_reg;
                for (int i = 0; i < N_ENT; i++)
                begin
                    rem2[i] = {1'b0, p2_mag_reg[i]};
                    t_in[i] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                vld_in = d_vld_reg[g-1];
                den_in = d_den_reg[g-1];
                neg_in = d_neg_reg[g-1];
                for (int i = 0; i < N_ENT; i++)
                begin
                    rem2[i] = {d_rem_reg[g-1][i], 1'b0};
                    t_in[i] = d_t_reg[g-1][i];
                end
            end
        end

        always_comb
        begin
            den_x = {1'b0, den_in};
            for (int i = 0; i < N_ENT; i++)
            begin
                diff[i]     = rem2[i] - den_x;
                qbit[i]     = rem2[i] >= den_x;
                rem_next[i] = qbit[i] ? diff[i][NORM_W-1:0] : rem2[i][NORM_W-1:0];
                t_next[i]   = {t_in[i][T_W-2:0], qbit[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_vld_reg[g] <= 1'b0;
            else if (adv)
                d_vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_den_reg[g] <= den_in;
                d_neg_reg[g] <= neg_in;
                d_rem_reg[g] <= rem_next;
                d_t_reg[g]   <= t_next;
            end
        end
    end

    // output stage: round half up on the extra bit, saturate, restore sign
    logic [CMP_W-1:0] qx_full [N_ENT];
    logic [16:0]      qsat [N_ENT];
    logic [OUT_W-1:0] ent [N_ENT];
    logic             zero_in;
    logic [143:0]     tdata_next;

    assign zero_in = (d_den_reg[DIV_ST-1] == '0);

    always_comb
    begin
        for (int i = 0; i < N_ENT; i++)
        begin
            qx_full[i] = (CMP_W'(d_t_reg[DIV_ST-1][i]) + CMP_W'(1)) >> 1;
            if (d_neg_reg[DIV_ST-1][i])
                qsat[i] = (qx_full[i] > CMP_W'(OUT_MIN_MAG)) ? 17'(OUT_MIN_MAG)
                                                            : qx_full[i][16:0];
            else
                qsat[i] = (qx_full[i] > CMP_W'(OUT_MAX)) ? 17'(OUT_MAX) : qx_full[i][16:0];
            ent[i] = d_neg_reg[DIV_ST-1][i] ? OUT_W'(~qsat[i] + 17'd1) : qsat[i][OUT_W-1:0];
        end
        if (zero_in)
        begin
            for (int i = 0; i < N_ENT; i++)
                ent[i] = '0;
            ent[0] = OUT_W'(ONE_VAL);
            ent[4] = OUT_W'(ONE_VAL);
            ent[8] = OUT_W'(ONE_VAL);
        end
        for (int i = 0; i < N_ENT; i++)
            tdata_next[i*OUT_W +: OUT_W] = ent[i];
    end

    logic             out_vld_reg;
    logic [143:0]     out_data_reg;
    logic             out_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= d_vld_reg[DIV_ST-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= tdata_next;
            out_zero_reg <= zero_in;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

    // zero norm gives zeros off the diagonal and one in m00
    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            m_tdata[31:16] == '0 && m_tdata[47:32] == '0 && m_tdata[63:48] == '0 &&
            m_tdata[95:80] == '0 && m_tdata[111:96] == '0 && m_tdata[127:112] == '0 &&
            m_tdata[15:0] == OUT_W'(ONE_VAL))
        else $error("zero norm result is not identity");

    // diagonal entries m00 and m22 never exceed one in magnitude
    a_diag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            $signed(m_tdata[15:0]) <= $signed(17'(ONE_VAL)) &&
            $signed(m_tdata[15:0]) >= -$signed(18'(DIAG_MIN_MAG)) &&
            $signed(m_tdata[143:128]) <= $signed(17'(ONE_VAL)) &&
            $signed(m_tdata[143:128]) >= -$signed(18'(DIAG_MIN_MAG)))
        else $error("diagonal entry beyond unit magnitude");

    // a stalled output holds the whole pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(d_vld_reg[DIV_ST-1]) && $stable(p2_vld_reg))
        else $error("pipeline advanced during output stall");
endmodule
`default_nettype wire

FILE: test/tb_quaternion_to_rotation_matrix_core.sv
`default_nettype none
module tb_quaternion_to_rotation_matrix_core;
    timeunit 1ns;
    timeprecision 1ps;
    import qrm_pkg::*;

    localparam int FB = DEFAULT_FRAC_BITS;
    localparam int LATENCY = FB + 5;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct {
        logic [15:0] ent [N_ENT];
        logic        zero_norm;
    } matrix_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [143:0] m_tdata;
    logic m_tuser;

    matrix_t pending_matrices [$];
    int errors;
    int quiet;
    int sent;

    quaternion_to_rotation_matrix_core #(.FRAC_BITS(FB)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // round(num * 2^FB / den), ties away from zero, saturated
    function automatic logic [15:0] scaled_ratio(longint num, longint den);
        bit neg;
        longint mag;
        longint q;
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag <<< FB;
        q = (2 * mag + den) / (2 * den);
        if (neg)
        begin
            if (q > OUT_MIN_MAG)
                q = OUT_MIN_MAG;
            return 16'(-q);
        end
        if (q > OUT_MAX)
            q = OUT_MAX;
        return 16'(q);
    endfunction

    function automatic matrix_t rotation_of(quat_t q);
        matrix_t m;
        longint w, x, y, z, n;
        longint one;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        n = w * w + x * x + y * y + z * z;
        m.zero_norm = (n == 0);
        if (n == 0)
        begin
            one = 64'd1 << FB;
            if (one > OUT_MAX)
                one = OUT_MAX;
            foreach (m.ent[i])
                m.ent[i] = 16'd0;
            m.ent[0] = 16'(one);
            m.ent[4] = 16'(one);
            m.ent[8] = 16'(one);
            return m;
        end
        m.ent[0] = scaled_ratio(n - 2 * (y * y + z * z), n);
        m.ent[1] = scaled_ratio(2 * (x * y - w * z), n);
        m.ent[2] = scaled_ratio(2 * (x * z + w * y), n);
        m.ent[3] = scaled_ratio(2 * (x * y + w * z), n);
        m.ent[4] = scaled_ratio(n - 2 * (x * x + z * z), n);
        m.ent[5] = scaled_ratio(2 * (y * z - w * x), n);
        m.ent[6] = scaled_ratio(2 * (x * z - w * y), n);
        m.ent[7] = scaled_ratio(2 * (y * z + w * x), n);
        m.ent[8] = scaled_ratio(n - 2 * (x * x + y * y), n);
        return m;
    endfunction

    task automatic send_quat(quat_t q);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {q.z, q.y, q.x, q.w};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_matrices.push_back(rotation_of(q));
        sent++;
    endtask

    function automatic quat_t random_quat();
        quat_t q;
        int mode;
        mode = $urandom_range(0, 5);
        q = quat_t'({$urandom, $urandom});
        if (mode == 1)
        begin
            // small magnitudes stress rounding
            q.w = 16'($signed($urandom_range(0, 15)) - 8);
            q.x = 16'($signed($urandom_range(0, 15)) - 8);
            q.y = 16'($signed($urandom_range(0, 15)) - 8);
            q.z = 16'($signed($urandom_range(0, 15)) - 8);
        end
        else if (mode == 2)
        begin
            if ($urandom_range(0, 1)) q.x = 0;
            if ($urandom_range(0, 1)) q.y = 0;
            if ($urandom_range(0, 1)) q.z = 0;
            if ($urandom_range(0, 1)) q.w = 0;
        end
        return q;
    endfunction

    // receiver side: random stalls, in-order compare
    always @(posedge clk)
    begin
        matrix_t exp_m;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_matrices.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %h/%b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                exp_m = pending_matrices.pop_front();
                for (int i = 0; i < N_ENT; i++)
                    if (m_tdata[16 * i +: 16] !== exp_m.ent[i])
                    begin
                        $display("%0t: entry %0d expected %h actual %h", $time, i,
                                 exp_m.ent[i], m_tdata[16 * i +: 16]);
                        errors++;
                    end
                if (m_tuser !== exp_m.zero_norm)
                begin
                    $display("%0t: zero_norm expected %b actual %b", $time,
                             exp_m.zero_norm, m_tuser);
                    errors++;
                end
            end
        end
    end

    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic test_directed();
        logic signed [15:0] ext [6] = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh4000,
                                        -16'sh4000, 16'sh0001};
        send_quat('{16'sh0, 16'sh0, 16'sh0, 16'sh0});
        send_quat('{16'sh4000, 16'sh0, 16'sh0, 16'sh0});
        send_quat('{16'sh0, 16'sh4000, 16'sh0, 16'sh0});
        send_quat('{16'sh0, 16'sh0, 16'sh4000, 16'sh0});
        send_quat('{16'sh0, 16'sh0, 16'sh0, 16'sh4000});
        send_quat('{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000});
        send_quat('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_quat('{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000});
        send_quat('{16'sh0001, 16'sh0, 16'sh0, 16'sh0});
        send_quat('{16'sh0, 16'sh0001, 16'sh0001, 16'sh0});
        send_quat('{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001});
        send_quat('{16'sh2d41, 16'sh2d41, 16'sh0, 16'sh0});
        for (int i = 0; i < 12; i++)
            send_quat('{ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                        ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)]});
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_quat(random_quat());
    endtask

    task automatic test_full_rate(int count);
        quiet = 1;
        test_random(count);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        quiet = 0;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1500);
        test_full_rate(300);
        s_tvalid <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
sv/qrm_pkg.sv
sv/quaternion_to_rotation_matrix_core.sv
test/tb_quaternion_to_rotation_matrix_core.sv
